[rtl/htlp_pkg.sv]
// Shared constants, codes and types for the linear-probe hash table engine.
package htlp_pkg;

  // Field widths of the request and response transactions
  localparam int CMD_W    = 2;
  localparam int HASH_W   = 64;
  localparam int KEY_W    = 32;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;
  localparam int LOAD_W   = 7;
  localparam int TAG_W    = 8;

  // Defaults for the top-level parameters
  localparam int SLOTS_DEF      = 16;
  localparam int KEY_BITS_DEF   = 32;
  localparam int VALUE_BITS_DEF = 32;

  // Load threshold handling
  localparam logic [LOAD_W-1:0] LOAD_DEFAULT = 7'd75;
  localparam int                PCT_FULL     = 100;

  // Slot tag codes; live tags hold the top seven hash bits with bit 7 clear
  localparam logic [TAG_W-1:0] TAG_EMPTY   = 8'h80;
  localparam logic [TAG_W-1:0] TAG_DELETED = 8'hFE;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_FIND   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ADD    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NO_ROOM   = 2'd2;

  // Sequencer states
  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_MOD,
    S_PROBE,
    S_APPLY,
    S_RESP
  } state_e;

  // Per-store write enables
  typedef struct packed {
    logic tag;
    logic hash;
    logic key;
    logic value;
  } wr_en_t;

  // One response transaction
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [VALUE_W-1:0]  found_value;
    logic [COUNT_W-1:0]  entry_count;
  } res_t;

endpackage

[rtl/htlp_if.sv]
// Valid/ready channel interfaces for requests and responses.
interface htlp_in_if;
  import htlp_pkg::*;

  logic                valid;
  logic                ready;
  logic [CMD_W-1:0]    cmd;
  logic [HASH_W-1:0]   lookup_hash;
  logic [KEY_W-1:0]    key;
  logic [VALUE_W-1:0]  value;

  modport source (output valid, cmd, lookup_hash, key, value, input ready);
  modport sink   (input valid, cmd, lookup_hash, key, value, output ready);
endinterface

interface htlp_out_if;
  import htlp_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [VALUE_W-1:0]  found_value;
  logic [COUNT_W-1:0]  entry_count;

  modport source (output valid, status, found_value, entry_count, input ready);
  modport sink   (input valid, status, found_value, entry_count, output ready);
endinterface

[rtl/htlp_store.sv]
// Slot storage: tag, hash, key and value memories with one write and one read port.
module htlp_store #(
  parameter int SLOTS      = htlp_pkg::SLOTS_DEF,
  parameter int KEY_BITS   = htlp_pkg::KEY_BITS_DEF,
  parameter int VALUE_BITS = htlp_pkg::VALUE_BITS_DEF,
  localparam int IDX_W     = $clog2(SLOTS),
  localparam int KW        = (KEY_BITS < htlp_pkg::KEY_W) ? KEY_BITS : htlp_pkg::KEY_W,
  localparam int VW        = (VALUE_BITS < htlp_pkg::VALUE_W) ? VALUE_BITS : htlp_pkg::VALUE_W
) (
  input  logic                         clk_i,
  input  htlp_pkg::wr_en_t             wr_en_i,
  input  logic [IDX_W-1:0]             wr_addr_i,
  input  logic [htlp_pkg::TAG_W-1:0]   wr_tag_i,
  input  logic [htlp_pkg::HASH_W-1:0]  wr_hash_i,
  input  logic [KW-1:0]                wr_key_i,
  input  logic [VW-1:0]                wr_value_i,
  input  logic [IDX_W-1:0]             rd_addr_i,
  output logic [htlp_pkg::TAG_W-1:0]   rd_tag_o,
  output logic [htlp_pkg::HASH_W-1:0]  rd_hash_o,
  output logic [KW-1:0]                rd_key_o,
  output logic [VW-1:0]                rd_value_o
);
  import htlp_pkg::*;

  logic [TAG_W-1:0]  tag_mem   [SLOTS];
  logic [HASH_W-1:0] hash_mem  [SLOTS];
  logic [KW-1:0]     key_mem   [SLOTS];
  logic [VW-1:0]     value_mem [SLOTS];

  // Write port, per-store enables
  always_ff @(posedge clk_i) begin
    if (wr_en_i.tag)   tag_mem[wr_addr_i]   <= wr_tag_i;
    if (wr_en_i.hash)  hash_mem[wr_addr_i]  <= wr_hash_i;
    if (wr_en_i.key)   key_mem[wr_addr_i]   <= wr_key_i;
    if (wr_en_i.value) value_mem[wr_addr_i] <= wr_value_i;
  end

  // Registered read port, one slot per cycle
  always_ff @(posedge clk_i) begin
    rd_tag_o   <= tag_mem[rd_addr_i];
    rd_hash_o  <= hash_mem[rd_addr_i];
    rd_key_o   <= key_mem[rd_addr_i];
    rd_value_o <= value_mem[rd_addr_i];
  end

endmodule

[rtl/htlp_ctrl.sv]
// Probe sequencer: home-slot reduction, slot compare loop, table update and live count.
module htlp_ctrl #(
  parameter int SLOTS      = htlp_pkg::SLOTS_DEF,
  parameter int KEY_BITS   = htlp_pkg::KEY_BITS_DEF,
  parameter int VALUE_BITS = htlp_pkg::VALUE_BITS_DEF,
  localparam int IDX_W     = $clog2(SLOTS),
  localparam int KW        = (KEY_BITS < htlp_pkg::KEY_W) ? KEY_BITS : htlp_pkg::KEY_W,
  localparam int VW        = (VALUE_BITS < htlp_pkg::VALUE_W) ? VALUE_BITS : htlp_pkg::VALUE_W
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [htlp_pkg::LOAD_W-1:0]  load_pct_i,
  htlp_in_if.sink                      in_i,
  output logic                         res_valid_o,
  output htlp_pkg::res_t               res_o,
  input  logic                         res_ready_i,
  // store ports
  output htlp_pkg::wr_en_t             wr_en_o,
  output logic [IDX_W-1:0]             wr_addr_o,
  output logic [htlp_pkg::TAG_W-1:0]   wr_tag_o,
  output logic [htlp_pkg::HASH_W-1:0]  wr_hash_o,
  output logic [KW-1:0]                wr_key_o,
  output logic [VW-1:0]                wr_value_o,
  output logic [IDX_W-1:0]             rd_addr_o,
  input  logic [htlp_pkg::TAG_W-1:0]   rd_tag_i,
  input  logic [htlp_pkg::HASH_W-1:0]  rd_hash_i,
  input  logic [KW-1:0]                rd_key_i,
  input  logic [VW-1:0]                rd_value_i
);
  import htlp_pkg::*;

  localparam int  CNT_W      = $clog2(SLOTS + 1);
  localparam int  LW         = CNT_W + LOAD_W;
  localparam bit  SLOTS_POW2 = (SLOTS & (SLOTS - 1)) == 0;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);
  localparam logic [CNT_W-1:0] SLOTS_C  = CNT_W'(SLOTS);
  localparam logic [CNT_W-1:0] LAST_C   = CNT_W'(SLOTS - 1);

  state_e state_q, state_d;

  logic [IDX_W-1:0]  rd_addr_q, rd_addr_d;
  logic [CNT_W-1:0]  iss_q, iss_d;
  logic              chk_vld_q, chk_vld_d;
  logic [IDX_W-1:0]  chk_addr_q, chk_addr_d;
  logic [CNT_W-1:0]  chk_n_q, chk_n_d;
  logic [3:0]        mod_cnt_q, mod_cnt_d;
  logic [CMD_W-1:0]  cmd_q, cmd_d;
  logic [HASH_W-1:0] hash_q, hash_d;
  logic [KW-1:0]     key_q, key_d;
  logic [VW-1:0]     val_q, val_d;
  logic              found_q, found_d;
  logic [IDX_W-1:0]  hit_q, hit_d;
  logic              have_free_q, have_free_d;
  logic [IDX_W-1:0]  free_q, free_d;
  logic [VW-1:0]     fval_q, fval_d;
  logic [CNT_W-1:0]  live_q, live_d;
  res_t              res_q, res_d;

  logic [TAG_W-1:0]  h1;
  logic              slot_empty, slot_del, slot_match, probe_done;
  logic [IDX_W-1:0]  mod_next;
  logic              over_load;
  logic [LOAD_W-1:0] lp;
  logic [LW-1:0]     load_lhs, load_rhs;
  logic [VW+VALUE_W-1:0] fval_ext;
  logic [CNT_W+COUNT_W-1:0] cnt_ext;

  assign h1 = {1'b0, hash_q[HASH_W-1 -: TAG_W-1]};

  // Slot compare on the registered read data
  always_comb begin
    slot_empty = rd_tag_i == TAG_EMPTY;
    slot_del   = rd_tag_i == TAG_DELETED;
    slot_match = (rd_tag_i == h1) && (rd_hash_i == hash_q) && (rd_key_i == key_q);
    probe_done = (state_q == S_PROBE) && chk_vld_q &&
                 (slot_empty || slot_match || (chk_n_q == LAST_C));
  end

  // Home-slot reduction, four hash bits per cycle, most significant first
  always_comb begin : mod_unit
    logic [IDX_W:0]   t;
    logic [IDX_W-1:0] r;
    logic [3:0]       nib;
    r   = rd_addr_q;
    nib = hash_q[{~mod_cnt_q, 2'b00} +: 4];
    for (int b = 3; b >= 0; b--) begin
      t = {r, nib[b]};
      if (t >= (IDX_W + 1)'(SLOTS)) t = t - (IDX_W + 1)'(SLOTS);
      r = t[IDX_W-1:0];
    end
    mod_next = r;
  end

  // Load threshold check for adds of new keys
  always_comb begin
    lp        = (load_pct_i == '0) ? LOAD_DEFAULT : load_pct_i;
    load_lhs  = (LW'(live_q) + LW'(1)) * LW'(PCT_FULL);
    load_rhs  = LW'(SLOTS) * LW'(lp);
    over_load = load_lhs >= load_rhs;
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR: if (rd_addr_q == LAST_IDX) state_d = S_IDLE;
      S_IDLE:  if (in_i.valid) state_d = SLOTS_POW2 ? S_PROBE : S_MOD;
      S_MOD:   if (mod_cnt_q == 4'hF) state_d = S_PROBE;
      S_PROBE: if (probe_done) state_d = S_APPLY;
      S_APPLY: state_d = S_RESP;
      S_RESP:  if (res_ready_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath and outputs
  always_comb begin
    rd_addr_d   = rd_addr_q;
    iss_d       = iss_q;
    chk_vld_d   = 1'b0;
    chk_addr_d  = rd_addr_q;
    chk_n_d     = chk_n_q;
    mod_cnt_d   = mod_cnt_q;
    cmd_d       = cmd_q;
    hash_d      = hash_q;
    key_d       = key_q;
    val_d       = val_q;
    found_d     = found_q;
    hit_d       = hit_q;
    have_free_d = have_free_q;
    free_d      = free_q;
    fval_d      = fval_q;
    live_d      = live_q;
    res_d       = res_q;

    in_i.ready  = state_q == S_IDLE;
    res_valid_o = state_q == S_RESP;
    rd_addr_o   = rd_addr_q;

    wr_en_o     = '0;
    wr_addr_o   = found_q ? hit_q : free_q;
    wr_tag_o    = (cmd_q == CMD_REMOVE) ? TAG_DELETED : h1;
    wr_hash_o   = hash_q;
    wr_key_o    = key_q;
    wr_value_o  = val_q;

    fval_ext    = '0;
    cnt_ext     = '0;

    unique case (state_q)
      // Sweep every tag to empty after reset
      S_CLEAR: begin
        wr_en_o.tag = 1'b1;
        wr_addr_o   = rd_addr_q;
        wr_tag_o    = TAG_EMPTY;
        rd_addr_d   = (rd_addr_q == LAST_IDX) ? '0 : rd_addr_q + 1'b1;
      end
      S_IDLE: begin
        if (in_i.valid) begin
          cmd_d       = in_i.cmd;
          hash_d      = in_i.lookup_hash;
          key_d       = in_i.key[KW-1:0];
          val_d       = in_i.value[VW-1:0];
          rd_addr_d   = SLOTS_POW2 ? in_i.lookup_hash[IDX_W-1:0] : '0;
          mod_cnt_d   = '0;
          iss_d       = '0;
          chk_n_d     = '0;
          found_d     = 1'b0;
          have_free_d = 1'b0;
          fval_d      = '0;
        end
      end
      S_MOD: begin
        rd_addr_d = mod_next;
        mod_cnt_d = mod_cnt_q + 1'b1;
      end
      // Issue one read per cycle, check the slot read in the cycle before
      S_PROBE: begin
        if (iss_q < SLOTS_C) begin
          chk_vld_d = 1'b1;
          iss_d     = iss_q + 1'b1;
          rd_addr_d = (rd_addr_q == LAST_IDX) ? '0 : rd_addr_q + 1'b1;
        end
        if (chk_vld_q) begin
          chk_n_d = chk_n_q + 1'b1;
          if ((slot_empty || slot_del) && !have_free_q) begin
            have_free_d = 1'b1;
            free_d      = chk_addr_q;
          end
          if (!slot_empty && !slot_del && slot_match) begin
            found_d = 1'b1;
            hit_d   = chk_addr_q;
            fval_d  = rd_value_i;
          end
        end
      end
      // Apply the command and build the response
      S_APPLY: begin
        res_d.status = ST_NOT_FOUND;
        fval_ext     = '0;
        case (cmd_q)
          CMD_ADD: begin
            if (found_q) begin
              wr_en_o.value = 1'b1;
              res_d.status  = ST_OK;
            end else if (over_load || !have_free_q) begin
              res_d.status = ST_NO_ROOM;
            end else begin
              wr_en_o      = '1;
              live_d       = live_q + 1'b1;
              res_d.status = ST_OK;
            end
          end
          CMD_REMOVE: begin
            if (found_q) begin
              wr_en_o.tag  = 1'b1;
              res_d.status = ST_OK;
              if (live_q != '0) live_d = live_q - 1'b1;
            end
          end
          default: begin
            if (found_q) begin
              res_d.status = ST_OK;
              fval_ext     = {{VALUE_W{1'b0}}, fval_q};
            end
          end
        endcase
        cnt_ext           = {{COUNT_W{1'b0}}, live_d};
        res_d.found_value = fval_ext[VALUE_W-1:0];
        res_d.entry_count = cnt_ext[COUNT_W-1:0];
      end
      S_RESP: ;
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      rd_addr_q <= '0;
      chk_vld_q <= 1'b0;
      live_q    <= '0;
    end else begin
      state_q   <= state_d;
      rd_addr_q <= rd_addr_d;
      chk_vld_q <= chk_vld_d;
      live_q    <= live_d;
    end
  end

  // Working registers of the current transaction
  always_ff @(posedge clk_i) begin
    iss_q       <= iss_d;
    chk_addr_q  <= chk_addr_d;
    chk_n_q     <= chk_n_d;
    mod_cnt_q   <= mod_cnt_d;
    cmd_q       <= cmd_d;
    hash_q      <= hash_d;
    key_q       <= key_d;
    val_q       <= val_d;
    found_q     <= found_d;
    hit_q       <= hit_d;
    have_free_q <= have_free_d;
    free_q      <= free_d;
    fval_q      <= fval_d;
    res_q       <= res_d;
  end

  assign res_o = res_q;

endmodule

[rtl/hash_table_linear_probe_engine_top.sv]
// Top level: load threshold register, probe sequencer, slot store and response register.
//
// Open-addressing hash table with linear probing over SLOTS slots.
// Requests arrive on in_i (valid/ready): cmd find, add/update or remove, a 64-bit
// key hash, key and value. Each request yields one response transaction on out_o
// with status, found value and the live entry count after the request.
// cfg_we_i/cfg_wdata_i write the load percent register (reset 75); write it only
// while no request is in flight.
// The probe loop examines 1 to SLOTS slots, reading one slot per cycle from the
// slot memory; the command is then applied and the response handed to the response
// register. When SLOTS is not a power of two, the home slot is first reduced four
// hash bits per cycle.
// One request is handled at a time; in_i.ready is high only when the sequencer is idle.
// After reset the tag memory is swept to empty before the first request is taken.
// A stalled out_o holds its response; the next request may still be accepted and
// processed, and its response waits until the register is free.
module hash_table_linear_probe_engine_top #(
  parameter int SLOTS      = htlp_pkg::SLOTS_DEF,
  parameter int KEY_BITS   = htlp_pkg::KEY_BITS_DEF,
  parameter int VALUE_BITS = htlp_pkg::VALUE_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [htlp_pkg::LOAD_W-1:0]  cfg_wdata_i,
  htlp_in_if.sink                      in_i,
  htlp_out_if.source                   out_o
);
  import htlp_pkg::*;

  localparam int IDX_W = $clog2(SLOTS);
  localparam int KW    = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;
  localparam int VW    = (VALUE_BITS < VALUE_W) ? VALUE_BITS : VALUE_W;

  logic [LOAD_W-1:0] load_pct_q;
  logic              out_vld_q, out_vld_d;
  res_t              out_q;
  logic              res_valid, res_ready;
  res_t              res;

  wr_en_t            wr_en;
  logic [IDX_W-1:0]  wr_addr, rd_addr;
  logic [TAG_W-1:0]  wr_tag, rd_tag;
  logic [HASH_W-1:0] wr_hash, rd_hash;
  logic [KW-1:0]     wr_key, rd_key;
  logic [VW-1:0]     wr_value, rd_value;

  // Load percent register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_pct_q <= LOAD_DEFAULT;
    end else if (cfg_we_i) begin
      load_pct_q <= cfg_wdata_i;
    end
  end

  htlp_ctrl #(
    .SLOTS      (SLOTS),
    .KEY_BITS   (KEY_BITS),
    .VALUE_BITS (VALUE_BITS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_pct_i  (load_pct_q),
    .in_i        (in_i),
    .res_valid_o (res_valid),
    .res_o       (res),
    .res_ready_i (res_ready),
    .wr_en_o     (wr_en),
    .wr_addr_o   (wr_addr),
    .wr_tag_o    (wr_tag),
    .wr_hash_o   (wr_hash),
    .wr_key_o    (wr_key),
    .wr_value_o  (wr_value),
    .rd_addr_o   (rd_addr),
    .rd_tag_i    (rd_tag),
    .rd_hash_i   (rd_hash),
    .rd_key_i    (rd_key),
    .rd_value_i  (rd_value)
  );

  htlp_store #(
    .SLOTS      (SLOTS),
    .KEY_BITS   (KEY_BITS),
    .VALUE_BITS (VALUE_BITS)
  ) u_store (
    .clk_i      (clk_i),
    .wr_en_i    (wr_en),
    .wr_addr_i  (wr_addr),
    .wr_tag_i   (wr_tag),
    .wr_hash_i  (wr_hash),
    .wr_key_i   (wr_key),
    .wr_value_i (wr_value),
    .rd_addr_i  (rd_addr),
    .rd_tag_o   (rd_tag),
    .rd_hash_o  (rd_hash),
    .rd_key_o   (rd_key),
    .rd_value_o (rd_value)
  );

  // Response register: free when empty or being taken this cycle
  assign res_ready = !out_vld_q || out_o.ready;

  always_comb begin
    out_vld_d = out_vld_q;
    if (out_o.ready) out_vld_d = 1'b0;
    if (res_valid && res_ready) out_vld_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) out_q <= res;
  end

  assign out_o.valid       = out_vld_q;
  assign out_o.status      = out_q.status;
  assign out_o.found_value = out_q.found_value;
  assign out_o.entry_count = out_q.entry_count;

endmodule
